// ===== rtl/lsi_pkg.sv =====
package lsi_pkg;

	localparam int MAX_BLOCK = 128;
	localparam int HIST = 7;
	localparam int PIX_W = 10;
	localparam int COL_W = $clog2(MAX_BLOCK);
	localparam int ROW_W = 3;
	localparam int ADDR_W = $clog2(HIST * MAX_BLOCK);
	localparam int QDEPTH = 4;
	localparam int PIX_MAX = 1023;

	typedef enum logic [1:0] {
		DIR_H  = 2'd0,
		DIR_V  = 2'd1,
		DIR_HV = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		MODE_INTER = 2'd0,
		MODE_UNI   = 2'd1,
		MODE_BI    = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REG_DIRECTION = 3'd0,
		REG_FRAC_X    = 3'd1,
		REG_FRAC_Y    = 3'd2,
		REG_OUT_MODE  = 3'd3,
		REG_WIDTH     = 3'd4,
		REG_HEIGHT    = 3'd5
	} reg_idx_t;

	// work packet from the front end to the filter back end
	typedef struct packed {
		logic [PIX_W-1:0]        pix;
		logic [HIST-1:0][PIX_W-1:0] taps;
		logic signed [15:0]      other;
		logic                    do_h;    // horizontal filter feeds result
		logic                    do_v;    // vertical filter used
		logic                    store;   // write line store
		logic                    emit;
		logic                    last;
		logic [COL_W-1:0]        col;
		logic [ROW_W-1:0]        row_mod; // r % 7
		dir_t                    dir;
		mode_t                   mode;
		logic [1:0]              fx;
		logic [1:0]              fy;
	} work_t;

	function automatic logic signed [7:0] coef(input logic [1:0] f, input int i);
		logic signed [7:0] c;
		c = 8'sd0;
		unique case (f)
			2'd1: case (i)
				0: c = -8'sd1; 1: c = 8'sd4; 2: c = -8'sd10; 3: c = 8'sd58;
				4: c = 8'sd17; 5: c = -8'sd5; 6: c = 8'sd1; default: c = 8'sd0;
			endcase
			2'd3: case (i)
				0: c = 8'sd0; 1: c = 8'sd1; 2: c = -8'sd5; 3: c = 8'sd17;
				4: c = 8'sd58; 5: c = -8'sd10; 6: c = 8'sd4; default: c = -8'sd1;
			endcase
			default: case (i)
				0: c = -8'sd1; 1: c = 8'sd4; 2: c = -8'sd11; 3: c = 8'sd40;
				4: c = 8'sd40; 5: c = -8'sd11; 6: c = 8'sd4; default: c = -8'sd1;
			endcase
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/lsi_front.sv =====
module lsi_front import lsi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [PIX_W-1:0]        ref_pixel,
	input  logic signed [15:0]      other_pred,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [7:0]              cfg_data,
	input  logic                    q_full,
	output logic                    q_push,
	output work_t                   q_data
);

	logic [1:0] dir_q, fx_q, fy_q, mode_q;
	logic [7:0] bw_q, bh_q;
	logic [7:0] col_q, row_q;
	logic [ROW_W-1:0] rmod_q;
	logic [HIST-1:0][PIX_W-1:0] taps_q;
	logic [8:0] w, h;
	logic acc;
	dir_t dir;
	logic [8:0] c, r, col;

	assign full = q_full;
	assign acc = push && !q_full;
	assign w = (bw_q == 8'd0) ? 9'd1 : (bw_q > 8'(MAX_BLOCK) ? 9'(MAX_BLOCK) : {1'b0, bw_q});
	assign h = (bh_q == 8'd0) ? 9'd1 : (bh_q > 8'(MAX_BLOCK) ? 9'(MAX_BLOCK) : {1'b0, bh_q});
	assign c = {1'b0, col_q};
	assign r = {1'b0, row_q};

	always_comb begin
		dir = (dir_q == 2'd3) ? DIR_HV : dir_t'(dir_q);
		q_data = '0;
		q_data.pix = ref_pixel;
		q_data.taps = taps_q;
		q_data.other = other_pred;
		q_data.dir = dir;
		q_data.mode = (mode_q == 2'd3) ? MODE_UNI : mode_t'(mode_q);
		q_data.fx = fx_q;
		q_data.fy = fy_q;
		q_data.row_mod = rmod_q;
		col = 9'd0;
		unique case (dir)
			DIR_H: begin
				col = c - 9'd7;
				q_data.do_h = 1'b1;
				q_data.emit = c >= 9'd7 && r >= 9'd3 && r < 9'd3 + h;
				q_data.last = q_data.emit && col == w - 9'd1 && r - 9'd3 == h - 9'd1;
			end
			DIR_V: begin
				col = c - 9'd3;
				q_data.store = c >= 9'd3 && c < 9'd3 + w;
				q_data.do_v = 1'b1;
				q_data.emit = q_data.store && r >= 9'd7;
				q_data.last = q_data.emit && col == w - 9'd1 && r - 9'd7 == h - 9'd1;
			end
			default: begin
				col = c - 9'd7;
				q_data.store = c >= 9'd7;
				q_data.do_h = 1'b1;
				q_data.do_v = 1'b1;
				q_data.emit = q_data.store && r >= 9'd7;
				q_data.last = q_data.emit && col == w - 9'd1 && r - 9'd7 == h - 9'd1;
			end
		endcase
		q_data.col = col[COL_W-1:0];
		q_push = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 2'd2; fx_q <= 2'd2; fy_q <= 2'd2; mode_q <= 2'd1;
			bw_q <= 8'd8; bh_q <= 8'd8;
			col_q <= '0; row_q <= '0; rmod_q <= '0; taps_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIRECTION: dir_q <= cfg_data[1:0];
				REG_FRAC_X:    fx_q <= cfg_data[1:0];
				REG_FRAC_Y:    fy_q <= cfg_data[1:0];
				REG_OUT_MODE:  mode_q <= cfg_data[1:0];
				REG_WIDTH:     bw_q <= cfg_data;
				REG_HEIGHT:    bh_q <= cfg_data;
				default: ;
			endcase
			if (cfg_index <= REG_HEIGHT) begin
				col_q <= '0; row_q <= '0; rmod_q <= '0;
			end
		end else if (acc) begin
			taps_q <= {ref_pixel, taps_q[HIST-1:1]};
			if (c >= w + 9'd6) begin
				col_q <= '0;
				if (r >= h + 9'd6) begin
					row_q <= '0; rmod_q <= '0;
				end else begin
					row_q <= row_q + 8'd1;
					rmod_q <= (rmod_q == ROW_W'(HIST - 1)) ? '0 : rmod_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 8'd1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_data.last |-> q_data.emit)
		else $error("last without emit");
	assert property (@(posedge clk) disable iff (!arst_n) rmod_q < ROW_W'(HIST))
		else $error("row modulo out of range");

endmodule

// ===== rtl/lsi_queue.sv =====
module lsi_queue import lsi_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  work_t wdata,
	output logic  full,
	input  logic  rd,
	output logic  empty,
	output work_t rdata
);

	localparam int PW = $clog2(QDEPTH);
	work_t mem_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;

	assign full = cnt_q == (PW+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= wp_q + 1'b1;
			if (rd && !empty) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(wr && !full) - (PW+1)'(rd && !empty);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (PW+1)'(QDEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		full |=> !(cnt_q == '0))
		else $error("queue emptied too fast");
	assert property (@(posedge clk) disable iff (!arst_n)
		empty && !wr |=> empty)
		else $error("queue filled without write");

endmodule

// ===== rtl/lsi_back.sv =====
module lsi_back import lsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  work_t              q_data,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] sample,
	output logic               last
);

	// stage 1: horizontal sum; stage 2: line store read issued;
	// stage 3: vertical sum and output formatting into the result register
	work_t w_s1;
	logic v_s1;
	logic signed [17:0] hv_s1;
	logic signed [16:0] rawv_s1;
	logic signed [15:0] cur_s1;
	work_t w_s2;
	logic v_s2;
	logic signed [15:0] bank_rd_s2 [HIST];
	logic signed [15:0] rd_s2 [HIST];
	logic [3:0] rot;
	logic signed [15:0] out_q;
	logic last_q, full_q;
	logic adv1, adv2, adv3;
	logic signed [23:0] hsum;
	logic signed [15:0] cur_s2;
	logic signed [31:0] vsum;
	logic signed [31:0] fin;
	logic signed [31:0] cl;

	// stage 2 feeds the result register; all stall while an emit waits for a free slot
	assign adv3 = v_s2 && w_s2.emit && (!full_q || pop);
	assign adv2 = !v_s2 || !w_s2.emit || !full_q || pop;
	assign adv1 = adv2;
	assign q_pop = !q_empty && adv1;
	assign empty = !full_q;
	assign sample = out_q;
	assign last = last_q;

	always_comb begin
		hsum = 24'sd0;
		for (int i = 0; i < HIST; i++)
			hsum += 24'(coef(q_data.fx, i)) * $signed({14'd0, q_data.taps[i]});
		hsum += 24'(coef(q_data.fx, 7)) * $signed({14'd0, q_data.pix});
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			w_s1 <= q_data;
			hv_s1 <= 18'(hsum >>> 2);
			rawv_s1 <= $signed({7'd0, q_data.pix});
		end
	end

	// value that this item leaves in the line store and feeds to the vertical sum
	assign cur_s1 = (w_s1.dir == DIR_V) ? 16'(rawv_s1) : 16'(hv_s1);

	// one bank per row slot; the old entry is read on the same edge that overwrites it
	for (genvar k = 0; k < HIST; k++) begin : g_bank
		logic signed [15:0] row_mem [MAX_BLOCK];
		always_ff @(posedge clk) begin
			if (adv2) begin
				if (v_s1 && w_s1.store && w_s1.row_mod == ROW_W'(k))
					row_mem[w_s1.col] <= cur_s1;
				bank_rd_s2[k] <= row_mem[w_s1.col];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			w_s2 <= w_s1;
			cur_s2 <= cur_s1;
		end
	end

	// tap i takes row slot (r + i) mod 7
	always_comb begin
		rot = 4'd0;
		for (int i = 0; i < HIST; i++) begin
			rot = 4'(w_s2.row_mod) + 4'(i);
			if (rot >= 4'(HIST)) rot = rot - 4'(HIST);
			rd_s2[i] = bank_rd_s2[rot[2:0]];
		end
	end

	always_comb begin
		vsum = 32'(coef(w_s2.fy, 7)) * 32'(cur_s2);
		for (int i = 0; i < HIST; i++)
			vsum += 32'(coef(w_s2.fy, i)) * 32'(rd_s2[i]);
		if (w_s2.dir == DIR_H) fin = 32'(cur_s2);
		else if (w_s2.dir == DIR_V) fin = vsum >>> 2;
		else fin = vsum >>> 6;
		unique case (w_s2.mode)
			MODE_INTER: cl = fin;
			MODE_BI:    cl = (fin + 32'(w_s2.other) + 32'sd16) >>> 5;
			default:    cl = (fin + 32'sd8) >>> 4;
		endcase
		if (w_s2.mode != MODE_INTER) begin
			if (cl < 0) cl = 0;
			else if (cl > PIX_MAX) cl = PIX_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; full_q <= 1'b0;
		end else begin
			if (adv1) v_s1 <= q_pop;
			if (adv2) v_s2 <= v_s1;
			if (adv3) full_q <= 1'b1;
			else if (pop) full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			out_q <= 16'(cl);
			last_q <= w_s2.last;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) adv3 |-> adv2)
		else $error("result stage ran ahead");
	assert property (@(posedge clk) disable iff (!arst_n)
		full_q && !pop |=> full_q && $stable(out_q))
		else $error("held result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");

endmodule

// ===== rtl/luma_subpel_8tap_interpolator.sv =====
// From push to result, an item passes the queue, stages 1 and 2, and the result register.
// Throughput: one item per cycle while pop keeps up; a 4-deep work queue
// decouples the front counters from the filter pipeline.
// Line store: 896 x 16 bit, not cleared; entries read before written are undefined.
// Reset (arst_n low) restores register defaults, zeroes counters and taps, empties queue.
module luma_subpel_8tap_interpolator import lsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [9:0]         ref_pixel,
	input  logic signed [15:0] other_pred,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] sample,
	output logic               last,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	logic qf, qe, qpush, qpop;
	work_t qin, qout;

	lsi_front u_front (
		.clk, .arst_n, .push, .full, .ref_pixel, .other_pred,
		.cfg_we, .cfg_index, .cfg_data,
		.q_full(qf), .q_push(qpush), .q_data(qin)
	);

	lsi_queue u_queue (
		.clk, .arst_n, .wr(qpush), .wdata(qin), .full(qf),
		.rd(qpop), .empty(qe), .rdata(qout)
	);

	lsi_back u_back (
		.clk, .arst_n, .q_empty(qe), .q_data(qout), .q_pop(qpop),
		.empty, .pop, .sample, .last
	);

endmodule
